@@ src/dq_pkg.sv @@
// Package: sizes, operation and status codes, and word conversion helpers for the deque.
`default_nettype none
package dq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;
  localparam int PORT_W     = 32;
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;

  localparam logic [KIND_W-1:0] KIND_ADD_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REM_FRONT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REM_BACK  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RD_FRONT  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RD_BACK   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic [CNT_W-1:0]   CNT_FULL   = CNT_W'(DEPTH);
  localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DEPTH);

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef struct packed {
    logic                wr_en;
    logic                rd_en;
    idx_t                addr;
    idx_t                front_next;
    cnt_t                count_next;
    logic [STATUS_W-1:0] status;
  } op_t;

  function automatic word_t to_word(input logic [PORT_W-1:0] v);
    word_t w;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      w[i] = (i < PORT_W) ? v[i] : 1'b0;
    end
    return w;
  endfunction

  function automatic logic [PORT_W-1:0] to_port(input word_t w);
    logic [PORT_W-1:0] v;
    for (int i = 0; i < PORT_W; i++) begin
      v[i] = (i < DATA_WIDTH) ? w[i] : 1'b0;
    end
    return v;
  endfunction

  function automatic logic [COUNT_W-1:0] to_count(input cnt_t c);
    logic [COUNT_W-1:0] v;
    for (int i = 0; i < COUNT_W; i++) begin
      v[i] = (i < CNT_W) ? c[i] : 1'b0;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

@@ src/dq_ptr.sv @@
// Operation decode: entry slot, memory access and next front index and count.
`default_nettype none
module dq_ptr
  import dq_pkg::*;
(
  input  wire logic [KIND_W-1:0] kind,
  input  wire idx_t              front,
  input  wire cnt_t              count,
  output op_t                    op
);

  logic [SUM_W-1:0] tail_sum;
  logic [SUM_W-1:0] back_sum;
  idx_t             tail_slot;
  idx_t             back_slot;
  idx_t             front_dec;
  idx_t             front_inc;
  cnt_t             count_dec;

  always_comb begin
    tail_sum = SUM_W'(front) + SUM_W'(count);
    back_sum = tail_sum - SUM_W'(1);
    tail_slot = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                            : IDX_W'(tail_sum);
    back_slot = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
                                            : IDX_W'(back_sum);
    front_dec = (front == '0) ? IDX_W'(DEPTH - 1) : front - IDX_W'(1);
    front_inc = (SUM_W'(front) + SUM_W'(1) >= SUM_W'(DEPTH)) ? '0 : front + IDX_W'(1);
    count_dec = count - CNT_W'(1);
  end

  always_comb begin
    op.wr_en      = 1'b0;
    op.rd_en      = 1'b0;
    op.addr       = front;
    op.front_next = front;
    op.count_next = count;
    op.status     = ST_OK;
    case (kind)
      KIND_ADD_FRONT, KIND_ADD_BACK: begin
        if (count >= CNT_FULL) begin
          op.status = ST_FULL;
        end else begin
          op.wr_en      = 1'b1;
          op.count_next = count + CNT_W'(1);
          if (kind == KIND_ADD_FRONT) begin
            op.addr       = front_dec;
            op.front_next = front_dec;
          end else begin
            op.addr = tail_slot;
          end
        end
      end
      KIND_REM_FRONT, KIND_REM_BACK, KIND_RD_FRONT, KIND_RD_BACK: begin
        if (count == '0) begin
          op.status = ST_EMPTY;
        end else begin
          op.rd_en = 1'b1;
          op.addr  = (kind == KIND_REM_FRONT || kind == KIND_RD_FRONT) ? front : back_slot;
          if (kind == KIND_REM_FRONT) begin
            op.front_next = front_inc;
            op.count_next = count_dec;
          end else if (kind == KIND_REM_BACK) begin
            op.count_next = count_dec;
          end
          if ((kind == KIND_REM_FRONT || kind == KIND_REM_BACK) && count_dec == '0) begin
            op.front_next = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/double_ended_queue.sv @@
// Top level: double-ended queue of data words on a ring buffer in one synchronous memory.
//
//  channel | signals                                        | role
//  --------+------------------------------------------------+--------------------------
//  in      | in_valid, in_ready, kind, value_in             | one operation per beat
//  out     | out_valid, out_ready, value_out, status,       | one result per operation
//          | is_empty, entry_count                          |
//
// An add, an error and an unused code register their result directly; a remove or read
// first registers the entry memory word, then the result in the read state.
// Reset clears the front index and count; the entry memory is not cleared.
// A new beat is taken only in the idle state while the result register is free or drained in that cycle.
// A stalled result holds in the output register until out_ready.
`default_nettype none
module double_ended_queue
  import dq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [KIND_W-1:0]   kind,
  input  wire logic [PORT_W-1:0]   value_in,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [PORT_W-1:0]        value_out,
  output logic [STATUS_W-1:0]      status,
  output logic                     is_empty,
  output logic [COUNT_W-1:0]       entry_count
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic  state;
  logic  state_next;
  idx_t  front;
  cnt_t  count;
  op_t   op;
  logic  accept;
  word_t mem [DEPTH];
  word_t mem_q;

  dq_ptr u_ptr (
    .kind  (kind),
    .front (front),
    .count (count),
    .op    (op)
  );

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept && op.wr_en) begin
      mem[op.addr] <= to_word(value_in);
    end
    if (accept && op.rd_en) begin
      mem_q <= mem[op.addr];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && op.rd_en) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        front     <= op.front_next;
        count     <= op.count_next;
        out_valid <= !op.rd_en;
      end else if (state == S_READ) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_out   <= '0;
      status      <= op.status;
      is_empty    <= (op.count_next == '0);
      entry_count <= to_count(op.count_next);
    end else if (state == S_READ) begin
      value_out <= to_port(mem_q);
    end
  end

endmodule
`default_nettype wire

@@ src/dq_checker.sv @@
// Port checker for the deque top level, with its bind statement.
`default_nettype none
module dq_checker
  import dq_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [PORT_W-1:0]   value_out,
  input wire logic [STATUS_W-1:0] status,
  input wire logic                is_empty,
  input wire logic [COUNT_W-1:0]  entry_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value_out) && $stable(status)
      && $stable(entry_count))
    else $error("result changed while stalled");

  a_stall_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while a result is stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> value_out == '0)
    else $error("error result carries a word");

  a_err_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |->
      (status == ST_EMPTY && is_empty) || (status == ST_FULL && entry_count == COUNT_FULL))
    else $error("error status disagrees with the held count");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .value_out   (value_out),
  .status      (status),
  .is_empty    (is_empty),
  .entry_count (entry_count)
);
`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for the double-ended queue: directed and random operations checked by a scoreboard.
`timescale 1ns / 1ps
module testbench;
  import dq_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_ITEMS = 50;
  localparam int PHASES      = 12;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    logic [PORT_W-1:0]   value;
    logic [STATUS_W-1:0] status;
    logic                empty;
    logic [COUNT_W-1:0]  count;
  } deque_result_t;

  class deque_scoreboard;
    word_t         slots [DEPTH];
    int            front;
    int            held;
    deque_result_t expected_results [$];
    int            failures;
    int            ops_taken;
    int            results_seen;
    int            full_errors;
    int            empty_errors;
    int            peak_held;

    function new();
      front = 0;
      held = 0;
      failures = 0;
      ops_taken = 0;
      results_seen = 0;
      full_errors = 0;
      empty_errors = 0;
      peak_held = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_op(logic [KIND_W-1:0] k, logic [PORT_W-1:0] v);
      deque_result_t res;
      int            slot;
      res.value = '0;
      res.status = ST_OK;
      ops_taken++;
      case (k)
        KIND_ADD_FRONT, KIND_ADD_BACK: begin
          if (held >= DEPTH) begin
            res.status = ST_FULL;
            full_errors++;
          end else if (k == KIND_ADD_FRONT) begin
            front = (front == 0) ? DEPTH - 1 : front - 1;
            slots[front] = word_t'(v);
            held++;
          end else begin
            slots[(front + held) % DEPTH] = word_t'(v);
            held++;
          end
        end
        KIND_REM_FRONT, KIND_REM_BACK, KIND_RD_FRONT, KIND_RD_BACK: begin
          if (held == 0) begin
            res.status = ST_EMPTY;
            empty_errors++;
          end else begin
            slot = (k == KIND_REM_FRONT || k == KIND_RD_FRONT) ? front
                                                                : (front + held - 1) % DEPTH;
            res.value = PORT_W'(slots[slot]);
            if (k == KIND_REM_FRONT) begin
              front = (front + 1) % DEPTH;
              held--;
            end else if (k == KIND_REM_BACK) begin
              held--;
            end
            if (held == 0) front = 0;
          end
        end
        default: begin
        end
      endcase
      if (held > peak_held) peak_held = held;
      res.empty = (held == 0);
      res.count = COUNT_W'(held);
      expected_results.push_back(res);
    endfunction

    function void check_result(deque_result_t got);
      deque_result_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("unexpected result: value=%h status=%0d empty=%0d count=%0d",
                   got.value, got.status, got.empty, got.count);
        return;
      end
      want = expected_results.pop_front();
      if (got.value !== want.value || got.status !== want.status ||
          got.empty !== want.empty || got.count !== want.count) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("mismatch at result %0d: expected value=%h status=%0d empty=%0d count=%0d, got value=%h status=%0d empty=%0d count=%0d",
                   results_seen, want.value, want.status, want.empty, want.count,
                   got.value, got.status, got.empty, got.count);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   kind = KIND_ADD_BACK;
  logic [PORT_W-1:0]   value_in = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [PORT_W-1:0]   value_out;
  logic [STATUS_W-1:0] status;
  logic                is_empty;
  logic [COUNT_W-1:0]  entry_count;

  deque_scoreboard sb = new();
  bit              steady = 1'b0;
  bit              hold_req = 1'b0;
  int              quiet_cycles = 0;

  double_ended_queue u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .value_in    (value_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value_out   (value_out),
    .status      (status),
    .is_empty    (is_empty),
    .entry_count (entry_count)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    deque_result_t got;
    if (!rst) begin
      if (in_valid && in_ready) sb.note_op(kind, value_in);
      if (out_valid && out_ready) begin
        got.value = value_out;
        got.status = status;
        got.empty = is_empty;
        got.count = entry_count;
        sb.check_result(got);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles", quiet_cycles);
      $display("FAIL double_ended_queue");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 27);
      end
    end
  end

  task automatic send_op(logic [KIND_W-1:0] k, logic [PORT_W-1:0] v);
    if (!steady && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    value_in <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_op(KIND_REM_FRONT, $urandom);
    send_op(KIND_REM_BACK, $urandom);
    send_op(KIND_RD_FRONT, $urandom);
    send_op(KIND_RD_BACK, $urandom);
    send_op(KIND_SPARE_LO, $urandom);
    send_op(KIND_SPARE_HI, $urandom);
    send_op(KIND_ADD_FRONT, '1);
    send_op(KIND_ADD_BACK, '0);
    send_op(KIND_RD_FRONT, $urandom);
    send_op(KIND_RD_BACK, $urandom);
    send_op(KIND_REM_BACK, $urandom);
    send_op(KIND_REM_FRONT, $urandom);
    for (int i = 0; i < DEPTH; i++) begin
      send_op((i % 2 == 0) ? KIND_ADD_BACK : KIND_ADD_FRONT, $urandom);
    end
    send_op(KIND_ADD_FRONT, '1);
    send_op(KIND_ADD_BACK, '0);
  endtask

  task automatic run_random(int n, int add_pct);
    logic [KIND_W-1:0] k;
    int                r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        k = ($urandom_range(1) == 0) ? KIND_SPARE_LO : KIND_SPARE_HI;
      end else if (r < 3 + add_pct) begin
        k = ($urandom_range(1) == 0) ? KIND_ADD_FRONT : KIND_ADD_BACK;
      end else begin
        case ($urandom_range(5))
          0, 1:    k = KIND_REM_FRONT;
          2, 3:    k = KIND_REM_BACK;
          4:       k = KIND_RD_FRONT;
          default: k = KIND_RD_BACK;
        endcase
      end
      send_op(k, $urandom);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      steady = (p == 3);
      if (p == 6) hold_req = 1'b1;
      if (p == 8) wait_drained();
      case (p % 3)
        0:       run_random(PHASE_ITEMS, 75);
        1:       run_random(PHASE_ITEMS, 25);
        default: run_random(PHASE_ITEMS, 50);
      endcase
    end
    steady = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    $display("operations %0d, results %0d, full errors %0d, empty errors %0d, peak count %0d",
             sb.ops_taken, sb.results_seen, sb.full_errors, sb.empty_errors, sb.peak_held);
    $display("failures %0d, results still owed %0d", sb.failures, sb.pending());
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS double_ended_queue");
    end else begin
      $display("FAIL double_ended_queue");
    end
    $finish;
  end

endmodule
